/* rtl/sbd_pkg.sv */
// sbd_pkg: constants and transfer types for the sponge boundary taper.
// No dependencies; imported by the top level.
package sbd_pkg;

    localparam int MAX_BAND  = 64;
    localparam int SAMPLE_W  = 24;
    localparam int COORD_W   = 13;
    localparam int WEIGHT_W  = 17;
    localparam int FRAC_W    = 16;
    localparam int IDX_W     = $clog2(MAX_BAND);
    localparam int BAND_W    = $clog2(MAX_BAND + 1);
    localparam int DIM_W     = COORD_W + 1;
    localparam int PROD_W    = SAMPLE_W + WEIGHT_W + 1;
    localparam int Q_W       = PROD_W - FRAC_W;

    localparam logic [1:0] SIDE_TOP    = 2'd0;
    localparam logic [1:0] SIDE_BOTTOM = 2'd1;
    localparam logic [1:0] SIDE_LEFT   = 2'd2;
    localparam logic [1:0] SIDE_RIGHT  = 2'd3;

    localparam logic CMD_SCALE = 1'b0;
    localparam logic CMD_LOAD  = 1'b1;

    typedef enum logic [2:0] {
        REG_IWIDTH = 3'd0,
        REG_IDEPTH = 3'd1,
        REG_TOP    = 3'd2,
        REG_BOTTOM = 3'd3,
        REG_LEFT   = 3'd4,
        REG_RIGHT  = 3'd5
    } t_reg_index;

    typedef struct packed {
        logic                       command;
        logic [COORD_W-1:0]         row;
        logic [COORD_W-1:0]         column;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic [1:0]                 table_side;
        logic [5:0]                 table_index;
        logic [WEIGHT_W-1:0]        table_weight;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] scaled_value;
        logic [COORD_W-1:0]         out_row;
        logic [COORD_W-1:0]         out_column;
        logic                       outside_grid;
    } t_out_item;

endpackage

/* rtl/sbd_ram.sv */
// sbd_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module sbd_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sponge_boundary_decay.sv */
// sponge_boundary_decay: absorbing-border taper for a padded 2-D wavefield.
// Depends on sbd_pkg and sbd_ram (four weight tables).
//
//   channel  | direction | handshake                   | payload
//   ---------+-----------+-----------------------------+-----------
//   in       | sink      | i_in_valid / o_in_stall     | t_in_item
//   out      | source    | o_out_valid / i_out_stall   | t_out_item
//   config   | APB slave | psel penable pwrite pready  | pwdata/prdata
//
// One item per cycle while the output does not stall; four register stages.
// Stages: decode and table read, multiply, shift and saturate, output register.
// A stall at the output freezes the whole pipeline, tables' read ports included.
// Reset clears valid bits and band registers and sets both interior sizes to one; the tables hold no reset value.
module sponge_boundary_decay
    import sbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [1:0] {RGN_NEAR, RGN_MID, RGN_FAR, RGN_OUT} t_region;
    typedef enum logic [2:0] {SEL_PASS, SEL_TOP, SEL_BOTTOM, SEL_LEFT, SEL_RIGHT} t_sel;

    // configuration
    logic [COORD_W-1:0] r_interior_width, r_interior_depth;
    logic [BAND_W-1:0]  r_top_band, r_bottom_band, r_left_band, r_right_band;
    logic [DIM_W-1:0]   r_vmid, r_rows, r_rows_m1, r_hmid, r_cols, r_cols_m1;
    logic               cfg_wr;
    logic [2:0]         cfg_idx;
    logic [BAND_W-1:0]  band_wdata;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];
    assign band_wdata = (pwdata[BAND_W-1:0] > BAND_W'(MAX_BAND)) ?
                        BAND_W'(MAX_BAND) : pwdata[BAND_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interior_width <= COORD_W'(1);
            r_interior_depth <= COORD_W'(1);
            r_top_band       <= '0;
            r_bottom_band    <= '0;
            r_left_band      <= '0;
            r_right_band     <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_IWIDTH: r_interior_width <= pwdata[COORD_W-1:0];
                REG_IDEPTH: r_interior_depth <= pwdata[COORD_W-1:0];
                REG_TOP:    r_top_band       <= band_wdata;
                REG_BOTTOM: r_bottom_band    <= band_wdata;
                REG_LEFT:   r_left_band      <= band_wdata;
                REG_RIGHT:  r_right_band     <= band_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_IWIDTH: prdata = 32'(r_interior_width);
            REG_IDEPTH: prdata = 32'(r_interior_depth);
            REG_TOP:    prdata = 32'(r_top_band);
            REG_BOTTOM: prdata = 32'(r_bottom_band);
            REG_LEFT:   prdata = 32'(r_left_band);
            REG_RIGHT:  prdata = 32'(r_right_band);
            default:    prdata = '0;
        endcase
    end

    // grid boundaries, registered from the config registers
    always_ff @(posedge i_clk) begin
        r_vmid    <= DIM_W'(r_top_band) + DIM_W'(r_interior_depth);
        r_rows    <= DIM_W'(r_top_band) + DIM_W'(r_interior_depth) + DIM_W'(r_bottom_band);
        r_rows_m1 <= DIM_W'(r_top_band) + DIM_W'(r_interior_depth) + DIM_W'(r_bottom_band)
                     - DIM_W'(1);
        r_hmid    <= DIM_W'(r_left_band) + DIM_W'(r_interior_width);
        r_cols    <= DIM_W'(r_left_band) + DIM_W'(r_interior_width) + DIM_W'(r_right_band);
        r_cols_m1 <= DIM_W'(r_left_band) + DIM_W'(r_interior_width) + DIM_W'(r_right_band)
                     - DIM_W'(1);
    end

    // pipeline control
    logic      r_out_valid;
    t_out_item r_out;
    logic      en;
    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    // stage A: registered input, region decode, table access
    logic      r_a_valid;
    t_in_item  r_a;
    t_region   vreg, hreg;
    logic [DIM_W-1:0] row_x, col_x, dv_far, dh_far;
    logic [IDX_W-1:0] dv, dh;
    t_sel      sel_a;
    logic      outside_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= i_in;
        end
    end

    assign row_x  = DIM_W'(r_a.row);
    assign col_x  = DIM_W'(r_a.column);
    assign dv_far = r_rows_m1 - row_x;
    assign dh_far = r_cols_m1 - col_x;

    always_comb begin
        dv = '0;
        dh = '0;
        if (row_x < DIM_W'(r_top_band)) begin
            vreg = RGN_NEAR;
            dv   = row_x[IDX_W-1:0];
        end else if (row_x < r_vmid) begin
            vreg = RGN_MID;
        end else if (row_x < r_rows) begin
            vreg = RGN_FAR;
            dv   = dv_far[IDX_W-1:0];
        end else begin
            vreg = RGN_OUT;
        end
        if (col_x < DIM_W'(r_left_band)) begin
            hreg = RGN_NEAR;
            dh   = col_x[IDX_W-1:0];
        end else if (col_x < r_hmid) begin
            hreg = RGN_MID;
        end else if (col_x < r_cols) begin
            hreg = RGN_FAR;
            dh   = dh_far[IDX_W-1:0];
        end else begin
            hreg = RGN_OUT;
        end

        outside_a = (vreg == RGN_OUT) || (hreg == RGN_OUT);
        if (outside_a || (vreg == RGN_MID && hreg == RGN_MID)) begin
            sel_a = SEL_PASS;
        end else if (hreg == RGN_MID) begin
            sel_a = (vreg == RGN_NEAR) ? SEL_TOP : SEL_BOTTOM;
        end else if (vreg == RGN_MID) begin
            sel_a = (hreg == RGN_NEAR) ? SEL_LEFT : SEL_RIGHT;
        end else if (dv > dh) begin
            sel_a = (hreg == RGN_NEAR) ? SEL_LEFT : SEL_RIGHT;
        end else begin
            sel_a = (vreg == RGN_NEAR) ? SEL_TOP : SEL_BOTTOM;
        end
    end

    // weight tables
    logic                load_ok;
    logic [3:0]          tab_we;
    logic [WEIGHT_W-1:0] w_top, w_bottom, w_left, w_right;

    assign load_ok = en && r_a_valid && (r_a.command == CMD_LOAD) &&
                     (BAND_W'(r_a.table_index) < BAND_W'(MAX_BAND));
    assign tab_we[0] = load_ok && (r_a.table_side == SIDE_TOP);
    assign tab_we[1] = load_ok && (r_a.table_side == SIDE_BOTTOM);
    assign tab_we[2] = load_ok && (r_a.table_side == SIDE_LEFT);
    assign tab_we[3] = load_ok && (r_a.table_side == SIDE_RIGHT);

    sbd_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_BAND)) u_top (
        .i_clk, .i_we(tab_we[0]), .i_waddr(r_a.table_index[IDX_W-1:0]),
        .i_wdata(r_a.table_weight), .i_re(en), .i_raddr(dv), .o_rdata(w_top)
    );
    sbd_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_BAND)) u_bottom (
        .i_clk, .i_we(tab_we[1]), .i_waddr(r_a.table_index[IDX_W-1:0]),
        .i_wdata(r_a.table_weight), .i_re(en), .i_raddr(dv), .o_rdata(w_bottom)
    );
    sbd_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_BAND)) u_left (
        .i_clk, .i_we(tab_we[2]), .i_waddr(r_a.table_index[IDX_W-1:0]),
        .i_wdata(r_a.table_weight), .i_re(en), .i_raddr(dh), .o_rdata(w_left)
    );
    sbd_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_BAND)) u_right (
        .i_clk, .i_we(tab_we[3]), .i_waddr(r_a.table_index[IDX_W-1:0]),
        .i_wdata(r_a.table_weight), .i_re(en), .i_raddr(dh), .o_rdata(w_right)
    );

    // stage B: weight select and multiply
    logic                       r_b_valid;
    t_sel                       r_b_sel;
    logic                       r_b_outside;
    logic signed [SAMPLE_W-1:0] r_b_sample;
    logic [COORD_W-1:0]         r_b_row, r_b_col;
    logic [WEIGHT_W-1:0]        w_b;
    logic signed [PROD_W-1:0]   prod_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid && (r_a.command == CMD_SCALE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_sel     <= sel_a;
            r_b_outside <= outside_a;
            r_b_sample  <= r_a.sample_value;
            r_b_row     <= r_a.row;
            r_b_col     <= r_a.column;
        end
    end

    always_comb begin
        case (r_b_sel)
            SEL_TOP:    w_b = w_top;
            SEL_BOTTOM: w_b = w_bottom;
            SEL_LEFT:   w_b = w_left;
            SEL_RIGHT:  w_b = w_right;
            default:    w_b = '0;
        endcase
    end

    assign prod_b = PROD_W'(r_b_sample) * $signed(PROD_W'(w_b));

    // stage C: floor shift and saturate
    logic                       r_c_valid;
    logic                       r_c_pass;
    logic                       r_c_outside;
    logic signed [SAMPLE_W-1:0] r_c_sample;
    logic signed [PROD_W-1:0]   r_c_prod;
    logic [COORD_W-1:0]         r_c_row, r_c_col;
    logic [Q_W-1:0]             q_c;
    logic                       ovf_c;
    logic [SAMPLE_W-1:0]        sat_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_pass    <= (r_b_sel == SEL_PASS);
            r_c_outside <= r_b_outside;
            r_c_sample  <= r_b_sample;
            r_c_prod    <= prod_b;
            r_c_row     <= r_b_row;
            r_c_col     <= r_b_col;
        end
    end

    assign q_c   = r_c_prod[PROD_W-1:FRAC_W];
    assign ovf_c = !(&q_c[Q_W-1:SAMPLE_W-1]) && (|q_c[Q_W-1:SAMPLE_W-1]);
    assign sat_c = !ovf_c ? q_c[SAMPLE_W-1:0] :
                   q_c[Q_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} :
                                {1'b0, {(SAMPLE_W-1){1'b1}}};

    // stage D: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.scaled_value <= r_c_pass ? r_c_sample : $signed(sat_c);
            r_out.out_row      <= r_c_row;
            r_out.out_column   <= r_c_col;
            r_out.outside_grid <= r_c_outside;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // checks
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_valid)
        else $error("input stalled with empty output register");

    a_c_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_c_valid |=> r_out_valid)
        else $error("result lost between saturate stage and output");

    a_outside_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && r_b_outside |-> r_b_sel == SEL_PASS)
        else $error("outside sample selected a weight table");

endmodule
